// ----- rtl/ssl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and codes for the setpoint schedule lookup block.
// ----------------------------------------------------------------------------
package ssl_pkg;

  // Field widths fixed by the item format.
  localparam int TIME_W  = 17;
  localparam int VALUE_W = 16;
  localparam int PIDX_W  = 8;

  // Operation codes decided by the front end.
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_DROP   = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_NO_SCHEDULE  = 2'd1;
  localparam status_t ST_LOADED       = 2'd2;
  localparam status_t ST_OUT_OF_RANGE = 2'd3;

  // One classified item waiting in the queue. The time field carries the
  // point time for a load and the current time for a lookup.
  typedef struct packed {
    op_t                        op;
    logic [PIDX_W-1:0]          index;
    logic [TIME_W-1:0]          stamp;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } cmd_t;

endpackage

// ----- rtl/ssl_front.sv -----
// ----------------------------------------------------------------------------
// ssl_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ssl_front import ssl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [PIDX_W-1:0]         in_point_index,
  input  logic [TIME_W-1:0]         in_point_time,
  input  logic signed [VALUE_W-1:0] in_point_value,
  input  logic                      in_last_point,
  input  logic [TIME_W-1:0]         in_now_seconds,
  output logic                      q_valid,
  output cmd_t                      q_cmd,
  input  logic                      q_pop
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  // Classify the incoming beat.
  always_comb begin
    cmd_in.index = in_point_index;
    cmd_in.value = in_point_value;
    cmd_in.last  = in_last_point;
    if (in_command) begin
      cmd_in.op    = OP_LOOKUP;
      cmd_in.stamp = in_now_seconds;
    end else begin
      cmd_in.stamp = in_point_time;
      if ({1'b0, in_point_index} >= (PIDX_W+1)'(MAX_POINTS)) begin
        cmd_in.op = OP_DROP;
      end else begin
        cmd_in.op = OP_LOAD;
      end
    end
  end

  // Queue pointers and fill level.
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/ssl_back.sv -----
// ----------------------------------------------------------------------------
// ssl_back
// Schedule table, search walk sequencer and result register.
// ----------------------------------------------------------------------------
module ssl_back import ssl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_setpoint,
  output logic [1:0]                out_status
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = TIME_W + VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FWD  = 2'd1;
  localparam logic [1:0] S_BWD  = 2'd2;
  localparam logic [1:0] S_WRAP = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic [IDX_W-1:0]          last_r, last_nxt;
  logic [TIME_W-1:0]         now_r, now_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          sidx_r, sidx_nxt;
  logic signed [VALUE_W-1:0] cur_r, cur_nxt;

  logic [WORD_W-1:0]         mem [MAX_POINTS];
  logic [WORD_W-1:0]         rd_r;
  logic [IDX_W-1:0]          raddr;
  logic [IDX_W-1:0]          waddr;
  logic                      we;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_setpoint_r;
  status_t                   out_status_r;
  logic                      res_load;
  logic signed [VALUE_W-1:0] res_sp;
  status_t                   res_st;

  logic                      out_free;
  logic [TIME_W-1:0]         rtime;
  logic signed [VALUE_W-1:0] rvalue;
  logic [IDX_W-1:0]          last_w;
  logic [IDX_W-1:0]          kc;
  logic [IDX_W:0]            k_plus1;

  assign out_free = !out_valid_r || !out_stall;
  assign rtime    = rd_r[WORD_W-1:VALUE_W];
  assign rvalue   = signed'(rd_r[VALUE_W-1:0]);
  assign last_w   = IDX_W'(count_r - 1'b1);
  assign k_plus1  = {1'b0, k_r} + 1'b1;
  assign waddr    = IDX_W'(q_cmd.index);

  // Stale search index is clamped to the last point.
  always_comb begin
    if (CNT_W'(sidx_r) >= count_r) begin
      kc = last_w;
    end else begin
      kc = sidx_r;
    end
  end

  // Sequencer: one table read per cycle while walking.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    now_nxt   = now_r;
    count_nxt = count_r;
    sidx_nxt  = sidx_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    raddr     = k_r;
    res_load  = 1'b0;
    res_sp    = cur_r;
    res_st    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_LOAD: begin
              we = 1'b1;
              if (q_cmd.last) begin
                count_nxt = CNT_W'({1'b0, q_cmd.index} + 1'b1);
              end
              res_load = 1'b1;
              res_st   = ST_LOADED;
            end
            OP_LOOKUP: begin
              if (count_r == '0) begin
                res_load = 1'b1;
                res_st   = ST_NO_SCHEDULE;
              end else begin
                last_nxt = last_w;
                k_nxt    = kc;
                now_nxt  = q_cmd.stamp;
                if (kc < last_w) begin
                  raddr     = IDX_W'({1'b0, kc} + 1'b1);
                  state_nxt = S_FWD;
                end else begin
                  raddr     = kc;
                  state_nxt = S_BWD;
                end
              end
            end
            default: begin
              res_load = 1'b1;
              res_st   = ST_OUT_OF_RANGE;
            end
          endcase
        end
      end
      S_FWD: begin
        // Read data holds the time of point k + 1.
        if (rtime <= now_r) begin
          k_nxt = k_plus1[IDX_W-1:0];
          if (k_plus1 < {1'b0, last_r}) begin
            raddr = IDX_W'(k_plus1 + 1'b1);
          end else begin
            raddr     = k_plus1[IDX_W-1:0];
            state_nxt = S_BWD;
          end
        end else begin
          raddr     = k_r;
          state_nxt = S_BWD;
        end
      end
      S_BWD: begin
        // Read data holds point k.
        if (k_r != '0 && rtime > now_r) begin
          k_nxt = k_r - 1'b1;
          raddr = k_r - 1'b1;
        end else if (k_r == '0 && rtime > now_r) begin
          raddr     = last_r;
          state_nxt = S_WRAP;
        end else if (out_free) begin
          cur_nxt   = rvalue;
          sidx_nxt  = k_r;
          res_load  = 1'b1;
          res_sp    = rvalue;
          res_st    = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          raddr = k_r;
        end
      end
      S_WRAP: begin
        // Now is before the first point: take the last point's value.
        raddr = last_r;
        if (out_free) begin
          cur_nxt   = rvalue;
          sidx_nxt  = k_r;
          res_load  = 1'b1;
          res_sp    = rvalue;
          res_st    = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and schedule state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sidx_r  <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sidx_r  <= sidx_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // Walk registers need no reset.
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    last_r <= last_nxt;
    now_r  <= now_nxt;
  end

  // Schedule table with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {q_cmd.stamp, q_cmd.value};
    end
    rd_r <= mem[raddr];
  end

  // Result register: a new result may load while the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_setpoint_r <= res_sp;
      out_status_r   <= res_st;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_setpoint = out_setpoint_r;
  assign out_status   = out_status_r;

`ifndef SYNTH
  // A walk only runs with a loaded schedule.
  a_walk_has_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r != '0))
    else $error("search walk running with empty schedule");

  // The walk index never passes the last point.
  a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r <= last_r))
    else $error("search index beyond last point");

  // Queue entries are taken only while the sequencer is idle.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && q_valid))
    else $error("queue popped outside idle");

  // A successful lookup result follows a walk and updates the setpoint.
  a_ok_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_st == ST_OK) |=> (cur_r == out_setpoint_r))
    else $error("lookup result does not match kept setpoint");
`endif

endmodule

// ----- rtl/setpoint_schedule_lookup.sv -----
// A load, a dropped load or a lookup with no schedule passes through the queue
// and then loads the result register; a walking lookup first walks the table,
// reading one table entry per cycle and moving one point per step. A new item
// is taken only once a walk is done; the input queue holds two waiting beats.
// Reset clears the point count, search index, setpoint and queue; the table
// itself is not cleared, and the block accepts beats right after reset.
// ----------------------------------------------------------------------------
// setpoint_schedule_lookup
// Daily setpoint schedule: loads points and finds the setpoint for a time.
// ----------------------------------------------------------------------------
module setpoint_schedule_lookup import ssl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [PIDX_W-1:0]         in_point_index,
  input  logic [TIME_W-1:0]         in_point_time,
  input  logic signed [VALUE_W-1:0] in_point_value,
  input  logic                      in_last_point,
  input  logic [TIME_W-1:0]         in_now_seconds,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_setpoint,
  output logic [1:0]                out_status
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front end: classification and queue.
  ssl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_point_index (in_point_index),
    .in_point_time  (in_point_time),
    .in_point_value (in_point_value),
    .in_last_point  (in_last_point),
    .in_now_seconds (in_now_seconds),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  // Back end: table, walk and result register.
  ssl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_setpoint (out_setpoint),
    .out_status   (out_status)
  );

endmodule

// ----- tb/ssl_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssl_tb_pkg
// Codes and sizes shared by the setpoint schedule testbench files.
// ----------------------------------------------------------------------------
package ssl_tb_pkg;

  // Command bit of an input beat.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Number of schedule points the block under test is built with.
  localparam int TABLE_DEPTH = 16;

endpackage

// ----- tb/setpoint_schedule_lookup_check.sv -----
// ----------------------------------------------------------------------------
// setpoint_schedule_lookup_check
// Watches both channels of the schedule block, keeps its own copy of the
// schedule, predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
module setpoint_schedule_lookup_check import ssl_pkg::*, ssl_tb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic [PIDX_W-1:0]         in_point_index,
  input  logic [TIME_W-1:0]         in_point_time,
  input  logic signed [VALUE_W-1:0] in_point_value,
  input  logic                      in_last_point,
  input  logic [TIME_W-1:0]         in_now_seconds,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] out_setpoint,
  input  logic [1:0]                out_status,
  output int                        fail_count,
  output int                        pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] setpoint;
    status_t                   status;
  } sched_result_t;

  // Shadow schedule and the results still owed by the block.
  logic [TIME_W-1:0]         tbl_time [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
  int                        sched_count;
  int                        search_pos;
  logic signed [VALUE_W-1:0] cur_setpoint;
  sched_result_t             setpoint_fifo [$];

  // Applies one input beat to the shadow schedule and returns its result.
  function automatic sched_result_t schedule_step(
    input logic                      cmd,
    input logic [PIDX_W-1:0]         idx,
    input logic [TIME_W-1:0]         stamp,
    input logic signed [VALUE_W-1:0] value,
    input logic                      last_pt,
    input logic [TIME_W-1:0]         now
  );
    sched_result_t r;
    int            top_idx;
    int            k;
    if (cmd == CMD_LOAD) begin
      if (idx >= TABLE_DEPTH) begin
        r.status = ST_OUT_OF_RANGE;
      end else begin
        tbl_time[idx]  = stamp;
        tbl_value[idx] = value;
        if (last_pt) begin
          sched_count = int'(idx) + 1;
        end
        r.status = ST_LOADED;
      end
    end else if (sched_count == 0) begin
      r.status = ST_NO_SCHEDULE;
    end else begin
      // Clamp a stale index, walk forward, then back to the active point.
      top_idx = sched_count - 1;
      k = search_pos;
      if (k > top_idx) begin
        k = top_idx;
      end
      while (k < top_idx && tbl_time[k + 1] <= now) begin
        k++;
      end
      while (k > 0 && tbl_time[k] > now) begin
        k--;
      end
      // Before the first point the schedule wraps to the last one.
      if (k == 0 && tbl_time[0] > now) begin
        cur_setpoint = tbl_value[top_idx];
      end else begin
        cur_setpoint = tbl_value[k];
      end
      search_pos = k;
      r.status = ST_OK;
    end
    r.setpoint = cur_setpoint;
    return r;
  endfunction

  // Predict on every accepted input beat, compare on every result beat.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      sched_count  = 0;
      search_pos   = 0;
      cur_setpoint = '0;
      setpoint_fifo.delete();
      fail_count   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        setpoint_fifo.push_back(schedule_step(in_command, in_point_index, in_point_time,
                                              in_point_value, in_last_point,
                                              in_now_seconds));
      end
      if (out_valid && !out_stall) begin
        if (setpoint_fifo.size() == 0) begin
          $display("%0t: result beat with none expected, setpoint %0d status %0d",
                   $time, out_setpoint, out_status);
          fail_count++;
        end else begin
          want = setpoint_fifo.pop_front();
          if (out_setpoint !== want.setpoint) begin
            $display("%0t: setpoint mismatch, expected %0d, actual %0d",
                     $time, want.setpoint, out_setpoint);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending = setpoint_fifo.size();
  end

endmodule

// ----- tb/setpoint_schedule_lookup_test.sv -----
// ----------------------------------------------------------------------------
// setpoint_schedule_lookup_test
// Drives loads and lookups into the schedule block with random idle gaps and
// result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module setpoint_schedule_lookup_test import ssl_pkg::*, ssl_tb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                TOTAL_BEATS     = 2000;
  localparam int                HOLD_OFF_CYCLES = 400;
  localparam int                TAIL_CYCLES     = 40;
  localparam int                CYCLE_LIMIT     = 1000000;
  localparam logic [TIME_W-1:0] DAY_END         = 17'd86399;
  localparam logic [TIME_W-1:0] TIME_MAX        = 17'h1FFFF;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic                      in_command     = CMD_LOAD;
  logic [PIDX_W-1:0]         in_point_index = '0;
  logic [TIME_W-1:0]         in_point_time  = '0;
  logic signed [VALUE_W-1:0] in_point_value = '0;
  logic                      in_last_point  = 1'b0;
  logic [TIME_W-1:0]         in_now_seconds = '0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic signed [VALUE_W-1:0] out_setpoint;
  logic [1:0]                out_status;
  int                        fail_count;
  int                        pending;

  // Stimulus-side view of the table, used to keep lookups on written points.
  bit                        loaded [TABLE_DEPTH];
  logic [TIME_W-1:0]         gen_time [TABLE_DEPTH];
  int                        gen_count    = 0;
  int                        beats_sent   = 0;
  bit                        calm         = 1'b0;
  bit                        hold_off_req = 1'b0;
  int                        cycle_count  = 0;

  setpoint_schedule_lookup #(.MAX_POINTS(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_point_index(in_point_index),
    .in_point_time(in_point_time), .in_point_value(in_point_value),
    .in_last_point(in_last_point), .in_now_seconds(in_now_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_setpoint(out_setpoint), .out_status(out_status)
  );

  setpoint_schedule_lookup_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_point_index(in_point_index),
    .in_point_time(in_point_time), .in_point_value(in_point_value),
    .in_last_point(in_last_point), .in_now_seconds(in_now_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_setpoint(out_setpoint), .out_status(out_status),
    .fail_count(fail_count), .pending(pending)
  );

  // Clock and run limit.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long, none in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // A lookup is safe when every point below the count has been written.
  function automatic bit table_ready();
    for (int i = 0; i < gen_count; i++) begin
      if (!loaded[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] random_point_time();
    if ($urandom_range(0, 9) == 0) begin
      return TIME_W'($urandom_range(int'(DAY_END) + 1, int'(TIME_MAX)));
    end
    return TIME_W'($urandom_range(0, int'(DAY_END)));
  endfunction

  function automatic logic [TIME_W-1:0] random_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15 && gen_count > 0) begin
      return gen_time[$urandom_range(0, gen_count - 1)];
    end
    if (r < 25) begin
      return TIME_W'($urandom_range(0, 200));
    end
    if (r < 30) begin
      return TIME_W'($urandom_range(int'(DAY_END) + 1, int'(TIME_MAX)));
    end
    return TIME_W'($urandom_range(0, int'(DAY_END)));
  endfunction

  // Offers one beat after a random gap and holds it until it is taken.
  task automatic send_beat(
    input logic                      cmd,
    input logic [PIDX_W-1:0]         idx,
    input logic [TIME_W-1:0]         stamp,
    input logic signed [VALUE_W-1:0] value,
    input logic                      last_pt,
    input logic [TIME_W-1:0]         now
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_command     <= cmd;
    in_point_index <= idx;
    in_point_time  <= stamp;
    in_point_value <= value;
    in_last_point  <= last_pt;
    in_now_seconds <= now;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_LOAD && idx < TABLE_DEPTH) begin
      loaded[idx]   = 1'b1;
      gen_time[idx] = stamp;
      if (last_pt) begin
        gen_count = int'(idx) + 1;
      end
    end
    beats_sent++;
  endtask

  // Load with a random, unused now field.
  task automatic send_load(
    input logic [PIDX_W-1:0]         idx,
    input logic [TIME_W-1:0]         stamp,
    input logic signed [VALUE_W-1:0] value,
    input logic                      last_pt
  );
    send_beat(CMD_LOAD, idx, stamp, value, last_pt,
              TIME_W'($urandom_range(0, int'(TIME_MAX))));
  endtask

  // Lookup with random, unused point fields.
  task automatic send_lookup(input logic [TIME_W-1:0] now);
    send_beat(CMD_LOOKUP, PIDX_W'($urandom_range(0, 255)),
              TIME_W'($urandom_range(0, int'(TIME_MAX))),
              VALUE_W'($urandom), 1'($urandom_range(0, 1)), now);
  endtask

  // Loads a whole schedule of n points, then looks it up a few times.
  task automatic send_schedule(input int n);
    logic [TIME_W-1:0] stamps [$];
    int                lookups;
    for (int i = 0; i < n; i++) begin
      stamps.push_back(random_point_time());
    end
    if ($urandom_range(0, 99) < 85) begin
      stamps.sort();
    end
    for (int i = 0; i < n; i++) begin
      send_load(PIDX_W'(i), stamps[i], VALUE_W'($urandom),
                (i == n - 1) || ($urandom_range(0, 9) == 0));
    end
    lookups = $urandom_range(2, 8);
    repeat (lookups) begin
      send_lookup(random_now());
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int stall_left;
    int len;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          stall_left = len - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int  r;
    bit  second_hold_done;
    second_hold_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lookups and out-of-range loads before any schedule exists.
    send_lookup('0);
    send_lookup(TIME_MAX);
    send_load(8'd255, TIME_MAX, -16'sd1, 1'b1);
    send_load(8'd16, 17'd500, 16'sd42, 1'b1);
    send_lookup(17'd5);

    // A four point day with extreme values.
    send_load(8'd0, 17'd100, -16'sd32768, 1'b0);
    send_load(8'd1, 17'd3600, 16'sd32767, 1'b0);
    send_load(8'd2, 17'd43200, 16'sd0, 1'b0);
    send_load(8'd3, DAY_END, 16'sd1234, 1'b1);
    send_lookup(17'd0);        // before the first point: wraps to the last
    send_lookup(17'd100);      // exactly on a point
    send_lookup(DAY_END);      // forward walk to the end
    send_lookup(17'd3599);     // backward walk to the start
    send_lookup(TIME_MAX);     // beyond one day

    // Shrink the count under a stale search index, then grow it again.
    send_load(8'd1, 17'd3600, -16'sd5, 1'b1);
    send_lookup(DAY_END);
    send_load(8'd3, DAY_END, 16'sd99, 1'b1);

    // Times out of order are walked the same way.
    send_load(8'd2, 17'd50, 16'sd777, 1'b0);
    send_lookup(17'd60);
    send_lookup(17'd40000);
    send_load(8'd0, 17'd0, 16'sd321, 1'b1);
    send_lookup(17'd0);
    send_load(8'd15, TIME_MAX, 16'sd7, 1'b0);

    // Random part: whole schedules, lookup bursts and stray loads.
    hold_off_req = 1'b1;
    while (beats_sent < TOTAL_BEATS) begin
      if (!second_hold_done && beats_sent > TOTAL_BEATS / 2) begin
        hold_off_req = 1'b1;
        second_hold_done = 1'b1;
      end
      calm = ($urandom_range(0, 9) < 3);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 99) < 80) begin
          send_schedule($urandom_range(1, 6));
        end else begin
          send_schedule($urandom_range(7, TABLE_DEPTH));
        end
      end else if (r < 85) begin
        repeat ($urandom_range(1, 5)) begin
          if (table_ready()) begin
            send_lookup(random_now());
          end
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          send_load(PIDX_W'($urandom_range(TABLE_DEPTH, 255)), random_point_time(),
                    VALUE_W'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          send_load(PIDX_W'($urandom_range(0, TABLE_DEPTH - 1)), random_point_time(),
                    VALUE_W'($urandom), ($urandom_range(0, 9) < 3));
        end
        if (table_ready()) begin
          send_lookup(random_now());
        end
      end
    end
    calm = 1'b0;

    // Drain and let the block settle before the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
